[hw/rtl/istn_pkg.sv]
`default_nettype none

package istn_pkg;

  // largest number of refinement steps built into the pipeline
  localparam int MAX_NEWTON_STEPS = 4;
  localparam int STEP_W = $clog2(MAX_NEWTON_STEPS + 1);

  localparam logic signed [47:0] Q_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q_MIN   = 48'sh8000_0000_0000;
  localparam logic signed [47:0] THREE_Q = 48'sh0300_0000_0000;

  localparam logic [31:0]        EXP_RST   = 32'h0100_0000;
  localparam logic signed [47:0] C0_RST    = 48'sh0100_0000_0000;
  localparam logic signed [47:0] C1_RST    = 48'shFF80_0000_0000;
  localparam logic signed [47:0] C2_RST    = 48'sh0060_0000_0000;
  localparam logic signed [47:0] C3_RST    = 48'shFFB0_0000_0000;
  localparam logic [2:0]         STEPS_RST = 3'd2;

  typedef enum logic [2:0] {
    REG_EXP   = 3'd0,
    REG_C0    = 3'd1,
    REG_C1    = 3'd2,
    REG_C2    = 3'd3,
    REG_C3    = 3'd4,
    REG_STEPS = 3'd5
  } cfg_reg_t;

  // right shift applied after a product, rounding included
  typedef enum logic [1:0] {
    SH24 = 2'd0,
    SH40 = 2'd1,
    SH41 = 2'd2
  } shift_mode_t;

  // per-word data that travels along the pipeline
  typedef struct packed {
    logic               valid;
    logic [31:0]        z;
    logic signed [32:0] dz;
    logic signed [47:0] seed;
    logic signed [47:0] y;
    logic               sat;
    logic               ssat;
  } side_t;

  // {overflow, saturated sum}
  function automatic logic [48:0] sat_add(input logic signed [47:0] a,
                                          input logic signed [47:0] b);
    logic signed [48:0] s;
    logic [48:0]        r;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      r = {1'b1, (s[48] ? Q_MIN : Q_MAX)};
    end else begin
      r = {1'b0, s[47:0]};
    end
    return r;
  endfunction

  function automatic logic [48:0] sat_sub(input logic signed [47:0] a,
                                          input logic signed [47:0] b);
    logic signed [48:0] s;
    logic [48:0]        r;
    s = {a[47], a} - {b[47], b};
    if (s[48] != s[47]) begin
      r = {1'b1, (s[48] ? Q_MIN : Q_MAX)};
    end else begin
      r = {1'b0, s[47:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/inv_sqrt_taylor_newton_unit.sv]
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------------------
// in       | input     | in_valid / in_stall  | in_variance_in (z, q8.24)
// out      | output    | out_valid / out_stall| out_inv_sqrt_out, out_seed_out, out_saturated
// cfg      | input     | cfg_we               | cfg_index, cfg_wdata
//
// one word enters per cycle while in_stall is low
// the datapath is a chain of fifteen five-stage multipliers: three for the cubic seed,
// three for each newton step; steps beyond the configured count pass y through unchanged
// synchronous active-low reset clears all valid bits and loads the default coefficients
// the whole pipeline holds while a result sits in the output register under out_stall

module inv_sqrt_taylor_newton_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        in_variance_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_inv_sqrt_out,
  output logic signed [31:0]      out_seed_out,
  output logic                    out_saturated,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_wdata
);

  localparam int NS = istn_pkg::MAX_NEWTON_STEPS;

  // global advance: everything moves unless the output word is held
  logic en;

  // configuration registers
  logic [31:0]        z0_r;
  logic signed [47:0] c0_r, c1_r, c2_r, c3_r;
  logic [2:0]         steps_r;
  logic [istn_pkg::STEP_W-1:0] steps_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z0_r    <= istn_pkg::EXP_RST;
      c0_r    <= istn_pkg::C0_RST;
      c1_r    <= istn_pkg::C1_RST;
      c2_r    <= istn_pkg::C2_RST;
      c3_r    <= istn_pkg::C3_RST;
      steps_r <= istn_pkg::STEPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        istn_pkg::REG_EXP:   z0_r    <= cfg_wdata[31:0];
        istn_pkg::REG_C0:    c0_r    <= cfg_wdata;
        istn_pkg::REG_C1:    c1_r    <= cfg_wdata;
        istn_pkg::REG_C2:    c2_r    <= cfg_wdata;
        istn_pkg::REG_C3:    c3_r    <= cfg_wdata;
        istn_pkg::REG_STEPS: steps_r <= cfg_wdata[2:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // step count clamps at the number of built-in newton stages
  always_comb begin
    if (int'(steps_r) > NS) begin
      steps_eff = istn_pkg::STEP_W'(NS);
    end else begin
      steps_eff = istn_pkg::STEP_W'(steps_r);
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // input stage: capture z and form dz = z - z0 (exact, 33 bits)
  istn_pkg::side_t side0_r, side0_nxt;

  always_comb begin
    side0_nxt       = '0;
    side0_nxt.valid = in_valid;
    side0_nxt.z     = in_variance_in;
    side0_nxt.dz    = $signed({1'b0, in_variance_in}) - $signed({1'b0, z0_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side0_r <= '0;
    end else if (en) begin
      side0_r <= side0_nxt;
    end
  end

  // cubic seed in horner form: acc = sat(acc*dz >> 24 + ck), three rounds
  logic signed [47:0] h_op   [3];
  istn_pkg::side_t    h_side [3];
  logic signed [47:0] h_coef [3];
  logic signed [47:0] hp_acc_r [3];
  istn_pkg::side_t    hp_side_r [3];

  assign h_op[0]   = c3_r;
  assign h_side[0] = side0_r;
  assign h_coef[0] = c2_r;
  assign h_coef[1] = c1_r;
  assign h_coef[2] = c0_r;

  for (genvar i = 0; i < 3; i++) begin : g_horner
    logic signed [47:0] m_res;
    logic               m_sat;
    istn_pkg::side_t    m_side;
    logic [48:0]        sum;
    istn_pkg::side_t    p_side_nxt;

    istn_mulsh u_mul (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .a      (h_op[i]),
      .b      ({{15{h_side[i].dz[32]}}, h_side[i].dz}),
      .mode   (istn_pkg::SH24),
      .side_i (h_side[i]),
      .res    (m_res),
      .rsat   (m_sat),
      .side_o (m_side)
    );

    always_comb begin
      sum            = istn_pkg::sat_add(m_res, h_coef[i]);
      p_side_nxt     = m_side;
      p_side_nxt.sat = m_side.sat | m_sat | sum[48];
      if (i == 2) begin
        // last round gives the seed, which is also the starting y
        p_side_nxt.seed = sum[47:0];
        p_side_nxt.y    = sum[47:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hp_side_r[i] <= '0;
      end else if (en) begin
        hp_side_r[i] <= p_side_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hp_acc_r[i] <= sum[47:0];
      end
    end

    if (i < 2) begin : g_next
      assign h_op[i+1]   = hp_acc_r[i];
      assign h_side[i+1] = hp_side_r[i];
    end
  end

  // newton steps: y = y * (3 - z*y*y) / 2, one unrolled section per step
  istn_pkg::side_t n_side [NS+1];

  assign n_side[0] = hp_side_r[2];

  for (genvar k = 0; k < NS; k++) begin : g_newton
    istn_pkg::side_t    s_in;
    logic signed [47:0] t1;
    logic               t1_sat;
    istn_pkg::side_t    t1_side;
    istn_pkg::side_t    m2_in;
    logic signed [47:0] t2;
    logic               t2_sat;
    istn_pkg::side_t    t2_side;
    logic [48:0]        diff;
    logic signed [47:0] d_r;
    istn_pkg::side_t    d_side_r, d_side_nxt;
    logic signed [47:0] y3;
    logic               y3_sat;
    istn_pkg::side_t    y3_side;
    istn_pkg::side_t    c_side_r, c_side_nxt;
    logic               act;

    // step-local saturation starts clean and only counts if the step runs
    always_comb begin
      s_in      = n_side[k];
      s_in.ssat = 1'b0;
    end

    istn_mulsh u_yy (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .a      (s_in.y),
      .b      (s_in.y),
      .mode   (istn_pkg::SH40),
      .side_i (s_in),
      .res    (t1),
      .rsat   (t1_sat),
      .side_o (t1_side)
    );

    always_comb begin
      m2_in      = t1_side;
      m2_in.ssat = t1_side.ssat | t1_sat;
    end

    istn_mulsh u_zyy (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .a      ($signed({16'b0, m2_in.z})),
      .b      (t1),
      .mode   (istn_pkg::SH24),
      .side_i (m2_in),
      .res    (t2),
      .rsat   (t2_sat),
      .side_o (t2_side)
    );

    always_comb begin
      diff            = istn_pkg::sat_sub(istn_pkg::THREE_Q, t2);
      d_side_nxt      = t2_side;
      d_side_nxt.ssat = t2_side.ssat | t2_sat | diff[48];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_side_r <= '0;
      end else if (en) begin
        d_side_r <= d_side_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r <= diff[47:0];
      end
    end

    // the shift by 41 folds in the halving
    istn_mulsh u_upd (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .a      (d_side_r.y),
      .b      (d_r),
      .mode   (istn_pkg::SH41),
      .side_i (d_side_r),
      .res    (y3),
      .rsat   (y3_sat),
      .side_o (y3_side)
    );

    assign act = istn_pkg::STEP_W'(k) < steps_eff;

    always_comb begin
      c_side_nxt = y3_side;
      if (act) begin
        c_side_nxt.y   = y3;
        c_side_nxt.sat = y3_side.sat | y3_side.ssat | y3_sat;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        c_side_r <= '0;
      end else if (en) begin
        c_side_r <= c_side_nxt;
      end
    end

    assign n_side[k+1] = c_side_r;
  end

  // output conversion q8.40 -> q8.24: magnitude, round half away, then sign and clamp
  logic        f1_valid_r, f2_valid_r, out_valid_r;
  logic [47:0] f1_my_r, f1_ms_r;
  logic        f1_ny_r, f1_ns_r, f1_sat_r;
  logic [48:0] ry, rsd;
  logic [32:0] f2_my_r, f2_ms_r;
  logic        f2_ny_r, f2_ns_r, f2_sat_r;
  logic [31:0] y_nxt, s_nxt;
  logic        ysat, ssat;
  logic signed [31:0] out_y_r, out_s_r;
  logic        out_sat_r;

  istn_pkg::side_t fin;
  assign fin = n_side[NS];

  always_comb begin
    ry  = {1'b0, f1_my_r} + 49'h0_0000_0000_8000;
    rsd = {1'b0, f1_ms_r} + 49'h0_0000_0000_8000;
  end

  always_comb begin
    ysat = 1'b0;
    ssat = 1'b0;
    if (f2_ny_r) begin
      if (f2_my_r > 33'h0_8000_0000) begin
        ysat  = 1'b1;
        y_nxt = 32'h8000_0000;
      end else begin
        y_nxt = 32'(-f2_my_r);
      end
    end else begin
      if (f2_my_r > 33'h0_7FFF_FFFF) begin
        ysat  = 1'b1;
        y_nxt = 32'h7FFF_FFFF;
      end else begin
        y_nxt = f2_my_r[31:0];
      end
    end
    if (f2_ns_r) begin
      if (f2_ms_r > 33'h0_8000_0000) begin
        ssat  = 1'b1;
        s_nxt = 32'h8000_0000;
      end else begin
        s_nxt = 32'(-f2_ms_r);
      end
    end else begin
      if (f2_ms_r > 33'h0_7FFF_FFFF) begin
        ssat  = 1'b1;
        s_nxt = 32'h7FFF_FFFF;
      end else begin
        s_nxt = f2_ms_r[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r  <= 1'b0;
      f2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r  <= fin.valid;
      f2_valid_r  <= f1_valid_r;
      out_valid_r <= f2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_my_r   <= fin.y[47] ? unsigned'(-fin.y) : unsigned'(fin.y);
      f1_ms_r   <= fin.seed[47] ? unsigned'(-fin.seed) : unsigned'(fin.seed);
      f1_ny_r   <= fin.y[47];
      f1_ns_r   <= fin.seed[47];
      f1_sat_r  <= fin.sat;

      f2_my_r   <= ry[48:16];
      f2_ms_r   <= rsd[48:16];
      f2_ny_r   <= f1_ny_r;
      f2_ns_r   <= f1_ns_r;
      f2_sat_r  <= f1_sat_r;

      out_y_r   <= y_nxt;
      out_s_r   <= s_nxt;
      out_sat_r <= f2_sat_r | ysat | ssat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_inv_sqrt_out = out_y_r;
  assign out_seed_out     = out_s_r;
  assign out_saturated    = out_sat_r;

endmodule

`default_nettype wire

[hw/rtl/istn_mulsh.sv]
`default_nettype none

// signed 48x48 multiply, rounded right shift, saturate to q8.40; five stages
module istn_mulsh (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic signed [47:0]        a,
  input  wire logic signed [47:0]        b,
  input  wire istn_pkg::shift_mode_t     mode,
  input  wire istn_pkg::side_t           side_i,
  output logic signed [47:0]             res,
  output logic                           rsat,
  output istn_pkg::side_t                side_o
);

  // stage 1: magnitudes
  logic [47:0]             s1_ma_r, s1_mb_r;
  logic                    s1_neg_r;
  istn_pkg::shift_mode_t   s1_mode_r;
  istn_pkg::side_t         s1_side_r;
  // stage 2: partial products
  logic [47:0]             s2_hh_r, s2_hl_r, s2_lh_r, s2_ll_r;
  logic                    s2_neg_r;
  istn_pkg::shift_mode_t   s2_mode_r;
  istn_pkg::side_t         s2_side_r;
  // stage 3: full product
  logic [95:0]             s3_prod_r;
  logic [95:0]             s3_prod_nxt;
  logic [48:0]             mid;
  logic                    s3_neg_r;
  istn_pkg::shift_mode_t   s3_mode_r;
  istn_pkg::side_t         s3_side_r;
  // stage 4: rounded shift
  logic [96:0]             rs;
  logic [96:0]             q;
  logic [47:0]             s4_m_r;
  logic                    s4_ovf_r;
  logic                    s4_neg_r;
  istn_pkg::side_t         s4_side_r;
  // stage 5: sign and saturation
  logic signed [47:0]      res_r, res_nxt;
  logic                    rsat_r, rsat_nxt;
  istn_pkg::side_t         side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r <= '0;
      s2_side_r <= '0;
      s3_side_r <= '0;
      s4_side_r <= '0;
      side_r    <= '0;
    end else if (en) begin
      s1_side_r <= side_i;
      s2_side_r <= s1_side_r;
      s3_side_r <= s2_side_r;
      s4_side_r <= s3_side_r;
      side_r    <= s4_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ma_r   <= a[47] ? unsigned'(-a) : unsigned'(a);
      s1_mb_r   <= b[47] ? unsigned'(-b) : unsigned'(b);
      s1_neg_r  <= a[47] ^ b[47];
      s1_mode_r <= mode;

      s2_hh_r   <= s1_ma_r[47:24] * s1_mb_r[47:24];
      s2_hl_r   <= s1_ma_r[47:24] * s1_mb_r[23:0];
      s2_lh_r   <= s1_ma_r[23:0] * s1_mb_r[47:24];
      s2_ll_r   <= s1_ma_r[23:0] * s1_mb_r[23:0];
      s2_neg_r  <= s1_neg_r;
      s2_mode_r <= s1_mode_r;

      s3_prod_r <= s3_prod_nxt;
      s3_neg_r  <= s2_neg_r;
      s3_mode_r <= s2_mode_r;

      s4_m_r    <= q[47:0];
      s4_ovf_r  <= |q[96:48];
      s4_neg_r  <= s3_neg_r;

      res_r     <= res_nxt;
      rsat_r    <= rsat_nxt;
    end
  end

  always_comb begin
    mid         = {1'b0, s2_hl_r} + {1'b0, s2_lh_r};
    s3_prod_nxt = {s2_hh_r, s2_ll_r} + ({47'b0, mid} << 24);
  end

  always_comb begin
    case (s3_mode_r)
      istn_pkg::SH24: begin
        rs = {1'b0, s3_prod_r} + (97'd1 << 23);
        q  = rs >> 24;
      end
      istn_pkg::SH40: begin
        rs = {1'b0, s3_prod_r} + (97'd1 << 39);
        q  = rs >> 40;
      end
      default: begin
        rs = {1'b0, s3_prod_r} + (97'd1 << 40);
        q  = rs >> 41;
      end
    endcase
  end

  always_comb begin
    rsat_nxt = 1'b0;
    if (s4_neg_r) begin
      if (s4_ovf_r || (s4_m_r > 48'h8000_0000_0000)) begin
        res_nxt  = istn_pkg::Q_MIN;
        rsat_nxt = 1'b1;
      end else begin
        res_nxt = -$signed(s4_m_r);
      end
    end else begin
      if (s4_ovf_r || s4_m_r[47]) begin
        res_nxt  = istn_pkg::Q_MAX;
        rsat_nxt = 1'b1;
      end else begin
        res_nxt = $signed(s4_m_r);
      end
    end
  end

  assign res    = res_r;
  assign rsat   = rsat_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

[hw/rtl/istn_checker.sv]
`default_nettype none

module istn_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_inv_sqrt_out,
  input wire logic signed [31:0] out_seed_out,
  input wire logic               out_saturated
);

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inv_sqrt_out)
      && $stable(out_seed_out) && $stable(out_saturated))
    else $error("result word changed while stalled");

  // input backpressure only comes from a held output word
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a free output never blocks the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present right after reset");

endmodule

bind inv_sqrt_taylor_newton_unit istn_checker u_istn_checker (.*);

`default_nettype wire

[test/inv_sqrt_taylor_newton_unit_tb.sv]
`timescale 1ns / 1ps

module inv_sqrt_taylor_newton_unit_tb;

  // q8.40 signed range that the model clamps to
  localparam logic signed [47:0] QHI = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] QLO = 48'sh8000_0000_0000;
  localparam int LATENCY = 22 + 17 * istn_pkg::MAX_NEWTON_STEPS;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic signed [31:0] inv_sqrt;
    logic signed [31:0] seed;
    logic               sat;
  } isqrt_word_t;

  // one set of unit registers
  typedef struct {
    logic [31:0]        z0;
    logic signed [47:0] c0, c1, c2, c3;
    logic [2:0]         steps;
  } isqrt_cfg_t;

  class isqrt_scoreboard;
    isqrt_cfg_t  regs;
    isqrt_word_t pending[$];
    int          errors;

    function void set_defaults();
      regs.z0 = istn_pkg::EXP_RST; regs.c0 = istn_pkg::C0_RST; regs.c1 = istn_pkg::C1_RST;
      regs.c2 = istn_pkg::C2_RST; regs.c3 = istn_pkg::C3_RST;
      regs.steps = istn_pkg::STEPS_RST;
    endfunction

    function void write_reg(istn_pkg::cfg_reg_t idx, logic [47:0] d);
      case (idx)
        istn_pkg::REG_EXP:   regs.z0 = d[31:0];
        istn_pkg::REG_C0:    regs.c0 = d;
        istn_pkg::REG_C1:    regs.c1 = d;
        istn_pkg::REG_C2:    regs.c2 = d;
        istn_pkg::REG_C3:    regs.c3 = d;
        istn_pkg::REG_STEPS: regs.steps = d[2:0];
        default: ;
      endcase
    endfunction

    // clamp a wide signed value to q8.40
    function logic signed [47:0] clamp48(logic signed [159:0] v, ref bit s);
      if (v > 160'(QHI)) begin s = 1; return QHI; end
      if (v < 160'(QLO)) begin s = 1; return QLO; end
      return v[47:0];
    endfunction

    // product shifted right, rounded to nearest with ties away from zero
    function logic signed [47:0] mul_round(logic signed [63:0] a, logic signed [63:0] b,
                                           int sh, ref bit s);
      logic signed [159:0] p, m;
      p = 160'(a) * 160'(b);
      m = p < 0 ? -p : p;
      m = (m + (160'sd1 <<< (sh - 1))) >>> sh;
      return clamp48(p < 0 ? -m : m, s);
    endfunction

    function logic signed [31:0] to_q24(logic signed [47:0] v, ref bit s);
      logic signed [63:0] m;
      m = v < 0 ? -64'(v) : 64'(v);
      m = (m + 64'sd32768) >>> 16;
      if (v >= 0 && m > 64'sh7FFF_FFFF) begin s = 1; m = 64'sh7FFF_FFFF; end
      if (v < 0 && m > 64'sh8000_0000) begin s = 1; m = 64'sh8000_0000; end
      return v < 0 ? 32'(-m) : 32'(m);
    endfunction

    // predict the word for one accepted input
    function void note_input(logic [31:0] z);
      logic signed [63:0] zs, dz;
      logic signed [47:0] acc, y, t;
      isqrt_word_t w;
      bit s;
      int n;
      s = 0;
      zs = 64'(z);
      dz = zs - 64'(regs.z0);
      acc = regs.c3;
      acc = clamp48(160'(mul_round(acc, dz, 24, s)) + 160'(regs.c2), s);
      acc = clamp48(160'(mul_round(acc, dz, 24, s)) + 160'(regs.c1), s);
      acc = clamp48(160'(mul_round(acc, dz, 24, s)) + 160'(regs.c0), s);
      n = regs.steps > istn_pkg::MAX_NEWTON_STEPS ? istn_pkg::MAX_NEWTON_STEPS : regs.steps;
      y = acc;
      for (int k = 0; k < n; k++) begin
        t = mul_round(y, y, 40, s);
        t = mul_round(zs, t, 24, s);
        t = clamp48(160'(istn_pkg::THREE_Q) - 160'(t), s);
        y = mul_round(y, t, 41, s);
      end
      w.inv_sqrt = to_q24(y, s);
      w.seed = to_q24(acc, s);
      w.sat = s;
      pending = {pending, w};
    endfunction

    function void check_result(logic signed [31:0] inv, logic signed [31:0] sd, logic st);
      isqrt_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected word inv_sqrt_out=%h", inv);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (inv !== w.inv_sqrt) begin
        $error("inv_sqrt_out expected %h actual %h", w.inv_sqrt, inv); errors++;
      end
      if (sd !== w.seed) begin
        $error("seed_out expected %h actual %h", w.seed, sd); errors++;
      end
      if (st !== w.sat) begin
        $error("saturated expected %b actual %b", w.sat, st); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [31:0] in_variance_in;
  logic out_valid, out_stall;
  logic signed [31:0] out_inv_sqrt_out, out_seed_out;
  logic out_saturated;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [47:0] cfg_wdata;

  isqrt_scoreboard sb;
  longint cycles;
  int stall_mode;

  inv_sqrt_taylor_newton_unit u_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // result side: check every accepted word
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_inv_sqrt_out, out_seed_out, out_saturated);
  end

  // receiver stall pattern: phases of none, light, heavy, and periodic stalling
  always @(posedge clk) begin
    if (($urandom % 64) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom % 5) == 0;
      2: out_stall <= ($urandom % 3) != 0;
      default: out_stall <= (cycles % 7) < 2;
    endcase
  end

  // watchdog
  always @(posedge clk)
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end

  task automatic write_cfg(istn_pkg::cfg_reg_t idx, logic [47:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    cfg_we <= 1'b0;
  endtask

  // send one word and hold it until accepted
  task automatic send_word(logic [31:0] z);
    in_valid <= 1'b1;
    in_variance_in <= z;
    do @(posedge clk); while (in_stall);
    sb.note_input(z);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait until every expected word arrived, then let the pipe drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // random input, mostly near the expansion point, sometimes extremes
  function automatic logic [31:0] pick_z();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 255);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      3: return $urandom_range(0, 32'h0FFF_FFFF);
      default: return sb.regs.z0 + 32'($signed($urandom_range(0, 32'h0100_0000))
                                        - 32'sh0080_0000);
    endcase
  endfunction

  task automatic random_phase(int n);
    int k;
    k = 0;
    while (k < n) begin
      int burst;
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst && k < n; j++, k++) send_word(pick_z());
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    drain();
  endtask

  initial begin
    logic [31:0] corner_z [9];
    corner_z = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h0100_0000, 32'h0040_0000, 32'h0400_0000,
                 32'h7FFF_FFFF, 32'h00FF_FFFF};
    sb = new();
    sb.set_defaults();
    cycles = 0;
    stall_mode = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_variance_in = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = istn_pkg::REG_EXP;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners with reset coefficients, then step counts 0..7
    foreach (corner_z[i]) send_word(corner_z[i]);
    drain();
    for (int s = 0; s < 8; s += 1) begin
      write_cfg(istn_pkg::REG_STEPS, 48'(s));
      send_word(32'h0100_0000);
      send_word(32'h0180_0000);
      drain();
    end

    // extreme coefficients force internal saturation
    write_cfg(istn_pkg::REG_EXP, 48'h0000_FFFF_FFFF);
    write_cfg(istn_pkg::REG_C0, 48'h7FFF_FFFF_FFFF);
    write_cfg(istn_pkg::REG_C1, 48'h8000_0000_0000);
    write_cfg(istn_pkg::REG_C2, 48'h7FFF_FFFF_FFFF);
    write_cfg(istn_pkg::REG_C3, 48'h8000_0000_0000);
    write_cfg(istn_pkg::REG_STEPS, 48'd4);
    send_word(32'h0);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0100_0000);
    drain();
    random_phase(60);

    // expansion point 4.0: 1/2, -1/16, 3/256, -5/2048
    write_cfg(istn_pkg::REG_EXP, 48'h0000_0400_0000);
    write_cfg(istn_pkg::REG_C0, 48'h0080_0000_0000);
    write_cfg(istn_pkg::REG_C1, 48'hFFF0_0000_0000);
    write_cfg(istn_pkg::REG_C2, 48'h0003_0000_0000);
    write_cfg(istn_pkg::REG_C3, 48'hFFFF_6000_0000);
    write_cfg(istn_pkg::REG_STEPS, 48'd3);
    random_phase(200);

    // all registers random once, then expansion point and coefficients back to defaults
    write_cfg(istn_pkg::REG_EXP, 48'($urandom));
    write_cfg(istn_pkg::REG_C0, 48'({$urandom, $urandom} >> 16));
    write_cfg(istn_pkg::REG_C1, 48'({$urandom, $urandom} >> 16));
    write_cfg(istn_pkg::REG_C2, 48'({$urandom, $urandom} >> 16));
    write_cfg(istn_pkg::REG_C3, 48'({$urandom, $urandom} >> 16));
    write_cfg(istn_pkg::REG_STEPS, 48'($urandom_range(0, 7)));
    random_phase(140);

    write_cfg(istn_pkg::REG_EXP, 48'(istn_pkg::EXP_RST));
    write_cfg(istn_pkg::REG_C0, istn_pkg::C0_RST);
    write_cfg(istn_pkg::REG_C1, istn_pkg::C1_RST);
    write_cfg(istn_pkg::REG_C2, istn_pkg::C2_RST);
    write_cfg(istn_pkg::REG_C3, istn_pkg::C3_RST);
    write_cfg(istn_pkg::REG_STEPS, 48'd0);
    random_phase(150);
    write_cfg(istn_pkg::REG_STEPS, 48'd7);
    random_phase(250);

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
